[rtl/mph_pkg.sv]
// Shared constants, codes and handshake payload types of the min-heap priority queue.
package mph_pkg;

    // Fixed channel field widths
    localparam int FUNC_W     = 2;
    localparam int IN_PRIO_W  = 16;
    localparam int IN_TASK_W  = 8;
    localparam int POS_W      = 8;
    localparam int STATUS_W   = 2;
    localparam int OUT_PRIO_W = 16;
    localparam int OUT_TASK_W = 8;

    // Default sizing
    localparam int DEF_CAPACITY  = 256;
    localparam int DEF_PRIO_BITS = 16;
    localparam int DEF_TASK_BITS = 8;

    // Operation codes
    localparam logic [FUNC_W-1:0] FN_PUSH = 2'd0;
    localparam logic [FUNC_W-1:0] FN_POP  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_CHG  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    // Comparator operand selects (each picks a strict less-than)
    localparam int CMP_SEL_W = 2;
    localparam logic [CMP_SEL_W-1:0] CMP_E_RD = 2'd0;  // moving entry < read entry
    localparam logic [CMP_SEL_W-1:0] CMP_RD_C = 2'd1;  // read entry < chosen child
    localparam logic [CMP_SEL_W-1:0] CMP_C_E  = 2'd2;  // chosen child < moving entry
    localparam logic [CMP_SEL_W-1:0] CMP_RD_E = 2'd3;  // read entry < moving entry

    // One operation as accepted from the input channel
    typedef struct packed {
        logic [FUNC_W-1:0]    func;
        logic [IN_PRIO_W-1:0] prio_in;
        logic [IN_TASK_W-1:0] task_in;
        logic [POS_W-1:0]     position;
    } t_cmd;

    // One result as handed to the output channel
    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [OUT_PRIO_W-1:0] prio_out;
        logic [OUT_TASK_W-1:0] task_out;
    } t_rsp;

endpackage

[rtl/mph_in_if.sv]
// Input channel of the min-heap priority queue: valid/ready plus one operation.
interface mph_in_if;
    import mph_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [FUNC_W-1:0]    func;
    logic [IN_PRIO_W-1:0] prio_in;
    logic [IN_TASK_W-1:0] task_in;
    logic [POS_W-1:0]     position;

    modport source (output valid, func, prio_in, task_in, position, input ready);
    modport sink   (input valid, func, prio_in, task_in, position, output ready);
endinterface

[rtl/mph_out_if.sv]
// Output channel of the min-heap priority queue: valid/ready plus one result.
interface mph_out_if;
    import mph_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [OUT_PRIO_W-1:0] prio_out;
    logic [OUT_TASK_W-1:0] task_out;

    modport source (output valid, status, prio_out, task_out, input ready);
    modport sink   (input valid, status, prio_out, task_out, output ready);
endinterface

[rtl/mph_ram.sv]
// Heap entry storage: one write port and one read port with registered read data.
module mph_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 24,
    parameter int AW    = 8
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/mph_cmp.sv]
// Shared priority comparator: picks an operand pair and gives a strict less-than.
module mph_cmp #(
    parameter int PRIO_BITS = 16
) (
    input  logic [mph_pkg::CMP_SEL_W-1:0] i_sel,
    input  logic [PRIO_BITS-1:0]          i_e_prio,
    input  logic [PRIO_BITS-1:0]          i_c_prio,
    input  logic [PRIO_BITS-1:0]          i_rd_prio,
    output logic                          o_lt
);
    import mph_pkg::*;

    logic [PRIO_BITS-1:0] w_a;
    logic [PRIO_BITS-1:0] w_b;

    // operand routing
    always_comb begin
        case (i_sel)
            CMP_E_RD: begin
                w_a = i_e_prio;
                w_b = i_rd_prio;
            end
            CMP_RD_C: begin
                w_a = i_rd_prio;
                w_b = i_c_prio;
            end
            CMP_C_E: begin
                w_a = i_c_prio;
                w_b = i_e_prio;
            end
            CMP_RD_E: begin
                w_a = i_rd_prio;
                w_b = i_e_prio;
            end
            default: begin
                w_a = i_e_prio;
                w_b = i_rd_prio;
            end
        endcase
    end

    assign o_lt = (w_a < w_b);
endmodule

[rtl/mph_ctrl.sv]
// Heap sequencer: runs push, pop and change one level at a time over the shared RAM port.
module mph_ctrl #(
    parameter int CAPACITY  = 256,
    parameter int PRIO_BITS = 16,
    parameter int TASK_BITS = 8,
    parameter int IDX_W     = 8,
    parameter int CNT_W     = 9
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  mph_pkg::t_cmd                 i_cmd,
    input  logic                          i_ack,
    output logic                          o_idle,
    output logic                          o_done,
    output mph_pkg::t_rsp                 o_rsp,
    // heap RAM
    output logic                          o_we,
    output logic [IDX_W-1:0]              o_waddr,
    output logic [PRIO_BITS+TASK_BITS-1:0] o_wdata,
    output logic                          o_re,
    output logic [IDX_W-1:0]              o_raddr,
    input  logic [PRIO_BITS+TASK_BITS-1:0] i_rdata,
    // shared comparator
    output logic [mph_pkg::CMP_SEL_W-1:0] o_cmp_sel,
    output logic [PRIO_BITS-1:0]          o_e_prio,
    output logic [PRIO_BITS-1:0]          o_c_prio,
    output logic [PRIO_BITS-1:0]          o_rd_prio,
    input  logic                          i_lt
);
    import mph_pkg::*;

    localparam int ENT_W = PRIO_BITS + TASK_BITS;
    localparam int KID_W = IDX_W + 2;
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_UP       = 4'd1;
    localparam logic [3:0] S_UP_CMP   = 4'd2;
    localparam logic [3:0] S_POP_ROOT = 4'd3;
    localparam logic [3:0] S_POP_LAST = 4'd4;
    localparam logic [3:0] S_CHG_RD   = 4'd5;
    localparam logic [3:0] S_DN       = 4'd6;
    localparam logic [3:0] S_DN_L     = 4'd7;
    localparam logic [3:0] S_DN_R     = 4'd8;
    localparam logic [3:0] S_DN_CMP   = 4'd9;
    localparam logic [3:0] S_DONE     = 4'd10;

    logic [3:0]            r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [IDX_W-1:0]      r_hole, n_hole;
    logic [IDX_W-1:0]      r_c_idx, n_c_idx;
    logic [PRIO_BITS-1:0]  r_e_prio, n_e_prio;
    logic [TASK_BITS-1:0]  r_e_task, n_e_task;
    logic [PRIO_BITS-1:0]  r_c_prio, n_c_prio;
    logic [TASK_BITS-1:0]  r_c_task, n_c_task;
    logic [STATUS_W-1:0]   r_status, n_status;
    logic [OUT_PRIO_W-1:0] r_pout, n_pout;
    logic [OUT_TASK_W-1:0] r_tout, n_tout;

    logic [PRIO_BITS-1:0]  w_rd_prio;
    logic [TASK_BITS-1:0]  w_rd_task;
    logic [KID_W-1:0]      w_kid_l;
    logic [KID_W-1:0]      w_kid_r;
    logic [KID_W-1:0]      w_cnt_k;

    assign w_rd_prio = i_rdata[ENT_W-1:TASK_BITS];
    assign w_rd_task = i_rdata[TASK_BITS-1:0];
    // children of the hole: 2h+1 and 2h+2
    assign w_kid_l   = {1'b0, r_hole, 1'b1};
    assign w_kid_r   = {1'b0, r_hole, 1'b0} + KID_W'(2);
    assign w_cnt_k   = KID_W'(r_count);

    assign o_e_prio  = r_e_prio;
    assign o_c_prio  = r_c_prio;
    assign o_rd_prio = w_rd_prio;

    assign o_idle = (r_state == S_IDLE);
    assign o_done = (r_state == S_DONE);
    assign o_rsp  = '{status: r_status, prio_out: r_pout, task_out: r_tout};

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_hole    = r_hole;
        n_c_idx   = r_c_idx;
        n_e_prio  = r_e_prio;
        n_e_task  = r_e_task;
        n_c_prio  = r_c_prio;
        n_c_task  = r_c_task;
        n_status  = r_status;
        n_pout    = r_pout;
        n_tout    = r_tout;
        o_we      = 1'b0;
        o_waddr   = r_hole;
        o_wdata   = {r_e_prio, r_e_task};
        o_re      = 1'b0;
        o_raddr   = r_hole;
        o_cmp_sel = CMP_E_RD;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_status = ST_OK;
                    n_pout   = '0;
                    n_tout   = '0;
                    n_e_prio = PRIO_BITS'(i_cmd.prio_in);
                    n_e_task = TASK_BITS'(i_cmd.task_in);
                    n_state  = S_DONE;
                    case (i_cmd.func)
                        FN_PUSH: begin
                            if (r_count == CNT_W'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else begin
                                n_hole  = IDX_W'(r_count);
                                n_count = r_count + CNT_W'(1);
                                n_state = S_UP;
                            end
                        end
                        FN_POP: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                o_re    = 1'b1;
                                o_raddr = '0;
                                n_state = S_POP_ROOT;
                            end
                        end
                        FN_CHG: begin
                            if (CMP_W'(i_cmd.position) >= CMP_W'(r_count)) begin
                                n_status = ST_RANGE;
                            end else begin
                                o_re    = 1'b1;
                                o_raddr = IDX_W'(i_cmd.position);
                                n_hole  = IDX_W'(i_cmd.position);
                                n_state = S_CHG_RD;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            // sift up: fetch parent of the hole
            S_UP: begin
                if (r_hole == '0) begin
                    o_we    = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_re    = 1'b1;
                    o_raddr = (r_hole - IDX_W'(1)) >> 1;
                    n_c_idx = (r_hole - IDX_W'(1)) >> 1;
                    n_state = S_UP_CMP;
                end
            end

            // parent moves down into the hole while the entry is strictly smaller
            S_UP_CMP: begin
                o_cmp_sel = CMP_E_RD;
                o_we      = 1'b1;
                if (i_lt) begin
                    o_wdata = i_rdata;
                    n_hole  = r_c_idx;
                    n_state = S_UP;
                end else begin
                    n_state = S_DONE;
                end
            end

            // root arrives; fetch the last entry
            S_POP_ROOT: begin
                n_pout  = OUT_PRIO_W'(w_rd_prio);
                n_tout  = OUT_TASK_W'(w_rd_task);
                o_re    = 1'b1;
                o_raddr = IDX_W'(r_count - CNT_W'(1));
                n_state = S_POP_LAST;
            end

            S_POP_LAST: begin
                n_e_prio = w_rd_prio;
                n_e_task = w_rd_task;
                n_count  = r_count - CNT_W'(1);
                n_hole   = '0;
                n_state  = (r_count == CNT_W'(1)) ? S_DONE : S_DN;
            end

            // old entry arrives; direction from old vs new priority
            S_CHG_RD: begin
                o_cmp_sel = CMP_RD_E;
                n_e_task  = w_rd_task;
                n_state   = i_lt ? S_DN : S_UP;
            end

            // sift down: fetch left child if present
            S_DN: begin
                if (w_kid_l >= w_cnt_k) begin
                    o_we    = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_re    = 1'b1;
                    o_raddr = IDX_W'(w_kid_l);
                    n_c_idx = IDX_W'(w_kid_l);
                    n_state = S_DN_L;
                end
            end

            // left child taken as the candidate; fetch right if present
            S_DN_L: begin
                n_c_prio = w_rd_prio;
                n_c_task = w_rd_task;
                if (w_kid_r < w_cnt_k) begin
                    o_re    = 1'b1;
                    o_raddr = IDX_W'(w_kid_r);
                    n_state = S_DN_R;
                end else begin
                    n_state = S_DN_CMP;
                end
            end

            // right wins only when strictly smaller
            S_DN_R: begin
                o_cmp_sel = CMP_RD_C;
                if (i_lt) begin
                    n_c_prio = w_rd_prio;
                    n_c_task = w_rd_task;
                    n_c_idx  = r_c_idx + IDX_W'(1);
                end
                n_state = S_DN_CMP;
            end

            // child moves up while it is strictly smaller than the entry
            S_DN_CMP: begin
                o_cmp_sel = CMP_C_E;
                o_we      = 1'b1;
                if (i_lt) begin
                    o_wdata = {r_c_prio, r_c_task};
                    n_hole  = r_c_idx;
                    n_state = S_DN;
                end else begin
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                if (i_ack) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_hole   <= n_hole;
        r_c_idx  <= n_c_idx;
        r_e_prio <= n_e_prio;
        r_e_task <= n_e_task;
        r_c_prio <= n_c_prio;
        r_c_task <= n_c_task;
        r_status <= n_status;
        r_pout   <= n_pout;
        r_tout   <= n_tout;
    end
endmodule

[rtl/min_heap_priority_queue_core.sv]
// Binary min-heap priority queue of (priority, task id) entries: push, pop and change priority.
// One operation is in flight at a time. The heap lives in a RAM with one write port and one
// registered read port, and every step shares a single comparator, so that read port sets the
// time per item. A full, empty, out-of-range or unused operation leaves the RAM alone. A push
// moves the entry toward the root one level at a time. A pop reads the root and the last entry,
// then, if entries remain, sinks the last entry from the root one level at a time; a node with
// only a left child skips the read of the right child. A change reads the old entry, then climbs
// like a push or sinks like a pop. Input ready is high only while the sequencer is idle. A
// finished result waits in an output register, so the next item may be taken before the
// previous result is collected. While that register is still full, the next result waits in
// the sequencer and input ready stays low. No clearing pass is needed after reset: only
// entries below the entry count are read.
module min_heap_priority_queue_core #(
    parameter int CAPACITY  = mph_pkg::DEF_CAPACITY,
    parameter int PRIO_BITS = mph_pkg::DEF_PRIO_BITS,
    parameter int TASK_BITS = mph_pkg::DEF_TASK_BITS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    mph_in_if.sink   i_in,
    mph_out_if.source o_out
);
    import mph_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int ENT_W = PRIO_BITS + TASK_BITS;

    logic                 w_idle;
    logic                 w_done;
    logic                 w_start;
    logic                 w_ack;
    t_cmd                 w_cmd;
    t_rsp                 w_rsp;
    logic                 w_we;
    logic [IDX_W-1:0]     w_waddr;
    logic [ENT_W-1:0]     w_wdata;
    logic                 w_re;
    logic [IDX_W-1:0]     w_raddr;
    logic [ENT_W-1:0]     w_rdata;
    logic [CMP_SEL_W-1:0] w_cmp_sel;
    logic [PRIO_BITS-1:0] w_e_prio;
    logic [PRIO_BITS-1:0] w_c_prio;
    logic [PRIO_BITS-1:0] w_rd_prio;
    logic                 w_lt;

    logic r_out_valid, n_out_valid;
    t_rsp r_out;

    // input handshake
    assign i_in.ready = w_idle;
    assign w_start    = i_in.valid && w_idle;
    assign w_cmd      = '{func: i_in.func, prio_in: i_in.prio_in,
                          task_in: i_in.task_in, position: i_in.position};

    // result moves into the output register once the slot is free or being drained
    assign w_ack       = w_done && (!r_out_valid || o_out.ready);
    assign n_out_valid = w_ack ? 1'b1 : (o_out.ready ? 1'b0 : r_out_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ack) begin
            r_out <= w_rsp;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.status   = r_out.status;
    assign o_out.prio_out = r_out.prio_out;
    assign o_out.task_out = r_out.task_out;

    mph_ctrl #(
        .CAPACITY  (CAPACITY),
        .PRIO_BITS (PRIO_BITS),
        .TASK_BITS (TASK_BITS),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_cmd     (w_cmd),
        .i_ack     (w_ack),
        .o_idle    (w_idle),
        .o_done    (w_done),
        .o_rsp     (w_rsp),
        .o_we      (w_we),
        .o_waddr   (w_waddr),
        .o_wdata   (w_wdata),
        .o_re      (w_re),
        .o_raddr   (w_raddr),
        .i_rdata   (w_rdata),
        .o_cmp_sel (w_cmp_sel),
        .o_e_prio  (w_e_prio),
        .o_c_prio  (w_c_prio),
        .o_rd_prio (w_rd_prio),
        .i_lt      (w_lt)
    );

    mph_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (ENT_W),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    mph_cmp #(
        .PRIO_BITS (PRIO_BITS)
    ) u_cmp (
        .i_sel     (w_cmp_sel),
        .i_e_prio  (w_e_prio),
        .i_c_prio  (w_c_prio),
        .i_rd_prio (w_rd_prio),
        .o_lt      (w_lt)
    );
endmodule

[rtl/mph_chk.sv]
// Port-level checks of the min-heap priority queue and their binding to the top level.
module mph_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            i_in_ready,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [mph_pkg::STATUS_W-1:0]    i_status,
    input logic [mph_pkg::OUT_PRIO_W-1:0]  i_prio_out,
    input logic [mph_pkg::OUT_TASK_W-1:0]  i_task_out
);
    import mph_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_status) && $stable(i_prio_out) && $stable(i_task_out))
        else $error("result payload changed while stalled");

    // an accepted item keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready high right after an accepted item");

    // failed operations carry no entry
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != ST_OK) |-> (i_prio_out == '0) && (i_task_out == '0))
        else $error("error result with nonzero entry");
endmodule

bind min_heap_priority_queue_core mph_chk u_mph_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_status    (o_out.status),
    .i_prio_out  (o_out.prio_out),
    .i_task_out  (o_out.task_out)
);

[dv/mph_tb_pkg.sv]
// Scoreboard of the min-heap priority queue testbench: a heap mirror and the result check.
package mph_tb_pkg;
    import mph_pkg::*;

    class heap_mirror;
        localparam int CAP = DEF_CAPACITY;

        // Mirror of the heap array and its fill level
        bit [DEF_PRIO_BITS-1:0] prio_q [CAP];
        bit [DEF_TASK_BITS-1:0] tid_q [CAP];
        int unsigned            count;

        // Results owed by the block, oldest first
        t_rsp due_q [$];
        int   err_cnt;

        function new();
            count   = 0;
            err_cnt = 0;
        endfunction

        // Move an entry toward the root while strictly smaller than its parent
        function void sift_up(int unsigned at, bit [DEF_PRIO_BITS-1:0] p,
                              bit [DEF_TASK_BITS-1:0] t);
            int unsigned i;
            i = at;
            while (i != 0 && p < prio_q[(i - 1) / 2]) begin
                prio_q[i] = prio_q[(i - 1) / 2];
                tid_q[i]  = tid_q[(i - 1) / 2];
                i = (i - 1) / 2;
            end
            prio_q[i] = p;
            tid_q[i]  = t;
        endfunction

        // Move an entry toward the smaller child (left on ties) while strictly larger
        function void sift_down(int unsigned at, bit [DEF_PRIO_BITS-1:0] p,
                                bit [DEF_TASK_BITS-1:0] t);
            int unsigned hole;
            int unsigned kid;
            hole = at;
            kid  = 2 * at + 1;
            while (kid < count) begin
                if (kid + 1 < count && prio_q[kid] > prio_q[kid + 1])
                    kid++;
                if (p <= prio_q[kid])
                    break;
                prio_q[hole] = prio_q[kid];
                tid_q[hole]  = tid_q[kid];
                hole = kid;
                kid  = 2 * hole + 1;
            end
            prio_q[hole] = p;
            tid_q[hole]  = t;
        endfunction

        // Apply one accepted operation to the mirror and queue its result
        function void note_op(t_cmd c);
            t_rsp                   r;
            bit [DEF_PRIO_BITS-1:0] p;
            bit [DEF_PRIO_BITS-1:0] old_p;
            bit [DEF_TASK_BITS-1:0] t;
            r = '0;
            r.status = ST_OK;
            p = c.prio_in[DEF_PRIO_BITS-1:0];
            t = c.task_in[DEF_TASK_BITS-1:0];
            case (c.func)
                FN_PUSH: begin
                    if (count >= CAP) begin
                        r.status = ST_FULL;
                    end else begin
                        count++;
                        sift_up(count - 1, p, t);
                    end
                end
                FN_POP: begin
                    if (count == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.prio_out = prio_q[0];
                        r.task_out = tid_q[0];
                        count--;
                        if (count != 0)
                            sift_down(0, prio_q[count], tid_q[count]);
                    end
                end
                FN_CHG: begin
                    if (c.position >= count) begin
                        r.status = ST_RANGE;
                    end else begin
                        old_p = prio_q[c.position];
                        t     = tid_q[c.position];
                        if (p > old_p)
                            sift_down(c.position, p, t);
                        else
                            sift_up(c.position, p, t);
                    end
                end
                default: ;  // unused selector: plain ok, no change
            endcase
            due_q.push_back(r);
        endfunction

        // One line per mismatch, and a count
        task report(string what, int got_v, int want_v);
            err_cnt++;
            $display("[%0t] %s mismatch: got %0h want %0h", $time, what, got_v, want_v);
        endtask

        // Compare one result field by field with the oldest one due
        task check_rsp(t_rsp got);
            t_rsp want;
            if (due_q.size() == 0) begin
                report("unrequested result, status", got.status, 0);
                return;
            end
            want = due_q.pop_front();
            if (got.status !== want.status)
                report("status", got.status, want.status);
            if (got.prio_out !== want.prio_out)
                report("prio_out", got.prio_out, want.prio_out);
            if (got.task_out !== want.task_out)
                report("task_out", got.task_out, want.task_out);
        endtask
    endclass

endpackage

[dv/tb_top.sv]
// Top-level testbench of the min-heap priority queue: stimulus, handshakes and end check.
module tb_top;
    import mph_pkg::*;
    import mph_tb_pkg::*;

    localparam int CAP          = DEF_CAPACITY;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 60;
    localparam int HOLD_CYCLES  = 400;
    localparam logic [FUNC_W-1:0] FN_IDLE = 2'd3;  // unused selector

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_CHOKE} t_rx_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mph_in_if  in_if ();
    mph_out_if out_if ();

    min_heap_priority_queue_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    heap_mirror sb;
    int         burst_left = 1;
    bit         hold_req = 1'b0;
    int         cyc = 0;

    always #5 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cyc = cyc + 1;
        if (cyc >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic t_cmd mk_cmd(logic [FUNC_W-1:0] f, int p, int t, int pos);
        t_cmd c;
        c.func     = f;
        c.prio_in  = IN_PRIO_W'(p);
        c.task_in  = IN_TASK_W'(t);
        c.position = POS_W'(pos);
        return c;
    endfunction

    // Random operation; weights in percent, remainder goes to the unused selector
    function automatic t_cmd make_op(int push_w, int pop_w, int chg_w);
        t_cmd c;
        int   roll;
        int   pick;
        roll = $urandom_range(0, 99);
        pick = $urandom_range(0, 99);
        if (roll < push_w)
            c.func = FN_PUSH;
        else if (roll < push_w + pop_w)
            c.func = FN_POP;
        else if (roll < push_w + pop_w + chg_w)
            c.func = FN_CHG;
        else
            c.func = FN_IDLE;
        // small values force equal priorities, extremes hit the bounds
        if (pick < 30)
            c.prio_in = IN_PRIO_W'($urandom_range(0, 15));
        else if (pick < 36)
            c.prio_in = $urandom_range(0, 1) ? '1 : '0;
        else
            c.prio_in = IN_PRIO_W'($urandom);
        c.task_in = IN_TASK_W'($urandom);
        if (sb.count > 0 && $urandom_range(0, 99) < 85)
            c.position = POS_W'($urandom_range(0, sb.count - 1));
        else
            c.position = POS_W'($urandom);
        return c;
    endfunction

    // Offer one item, wait for acceptance, then maybe open a gap
    task automatic send_op(input t_cmd c);
        int gap;
        in_if.valid    <= 1'b1;
        in_if.func     <= c.func;
        in_if.prio_in  <= c.prio_in;
        in_if.task_in  <= c.task_in;
        in_if.position <= c.position;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        sb.note_op(c);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, 8);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Receiver: ready pattern in random segments, plus one long hold-off
    initial begin
        int       seg_left;
        int       hold_left;
        bit       hold_done;
        t_rx_mode mode;
        seg_left  = 0;
        hold_left = 0;
        hold_done = 1'b0;
        mode      = RX_OPEN;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n !== 1'b1) begin
                out_if.ready <= 1'b0;
            end else begin
                if (hold_req && !hold_done) begin
                    hold_left = HOLD_CYCLES;
                    hold_done = 1'b1;
                end
                if (hold_left > 0) begin
                    hold_left--;
                    out_if.ready <= 1'b0;
                end else begin
                    if (seg_left == 0) begin
                        mode     = t_rx_mode'($urandom_range(0, 3));
                        seg_left = $urandom_range(16, 64);
                    end
                    seg_left--;
                    case (mode)
                        RX_OPEN:   out_if.ready <= 1'b1;
                        RX_COIN:   out_if.ready <= 1'($urandom_range(0, 1));
                        RX_SPARSE: out_if.ready <= ($urandom_range(0, 3) == 0);
                        default:   out_if.ready <= ($urandom_range(0, 9) == 0);
                    endcase
                end
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin : mon_out
        t_rsp got;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            got.status   = out_if.status;
            got.prio_out = out_if.prio_out;
            got.task_out = out_if.task_out;
            sb.check_rsp(got);
        end
    end

    // Main sequence
    initial begin
        int n;
        sb = new();
        i_rst_n        <= 1'b0;
        in_if.valid    <= 1'b0;
        in_if.func     <= '0;
        in_if.prio_in  <= '0;
        in_if.task_in  <= '0;
        in_if.position <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty pop, range on empty, unused selector
        send_op(mk_cmd(FN_POP, 0, 0, 0));
        send_op(mk_cmd(FN_CHG, 0, 0, 0));
        send_op(mk_cmd(FN_IDLE, 16'hFFFF, 8'hFF, 8'hFF));
        // extremes and equal priorities
        send_op(mk_cmd(FN_PUSH, 16'hFFFF, 8'hFF, 0));
        send_op(mk_cmd(FN_PUSH, 0, 0, 0));
        send_op(mk_cmd(FN_PUSH, 0, 8'h11, 0));
        send_op(mk_cmd(FN_PUSH, 16'h8000, 8'hAA, 0));
        send_op(mk_cmd(FN_PUSH, 5, 8'h55, 0));
        send_op(mk_cmd(FN_PUSH, 5, 8'h56, 0));
        // change: equal, larger, smaller, range at the boundary and at the top
        send_op(mk_cmd(FN_CHG, sb.prio_q[0], 0, 0));
        send_op(mk_cmd(FN_CHG, 16'hFFFF, 0, 0));
        send_op(mk_cmd(FN_CHG, 0, 0, sb.count - 1));
        send_op(mk_cmd(FN_CHG, 7, 0, sb.count));
        send_op(mk_cmd(FN_CHG, 7, 0, 8'hFF));
        // drain, ending on an empty pop
        n = sb.count + 1;
        repeat (n) send_op(mk_cmd(FN_POP, 0, 0, 0));

        // Random mix
        repeat (40) send_op(make_op(45, 25, 25));

        // Fill to capacity under a long receiver hold-off
        hold_req = 1'b1;
        while (sb.count < CAP)
            send_op(make_op(92, 1, 6));
        repeat (12) send_op(make_op(55, 0, 43));

        // Closing pop-heavy mix from a full heap
        repeat (70) send_op(make_op(10, 75, 12));

        in_if.valid <= 1'b0;
        while (sb.due_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.err_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[min_heap_priority_queue_core.f]
rtl/mph_pkg.sv
rtl/mph_in_if.sv
rtl/mph_out_if.sv
rtl/mph_ram.sv
rtl/mph_cmp.sv
rtl/mph_ctrl.sv
rtl/min_heap_priority_queue_core.sv
rtl/mph_chk.sv
dv/mph_tb_pkg.sv
dv/tb_top.sv
